[rtl/rau_pkg.sv]
// rational arithmetic unit: shared types and constants
// no dependencies
package rau_pkg;

    localparam int NUM_W = 33;
    localparam int DEN_W = 32;
    localparam int WORK_W = 34;

    typedef enum logic [2:0] {
        FUNC_ADD = 3'd0,
        FUNC_SUB = 3'd1,
        FUNC_MUL = 3'd2,
        FUNC_DIV = 3'd3,
        FUNC_RED = 3'd4
    } func_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL1,
        ST_MUL2,
        ST_COMB,
        ST_GCD,
        ST_DIVN,
        ST_DIVD,
        ST_OUT
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic mul1;
        logic mul2;
        logic comb;
        logic gcd_step;
        logic div_start_n;
        logic div_start_d;
        logic div_step;
        logic fin_n;
        logic fin_d;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic zero_part;
        logic gcd_done;
        logic div_done;
    } sts_t;

endpackage

[rtl/rau_ctrl.sv]
// rational arithmetic unit: sequencing state machine
// depends on rau_pkg
module rau_ctrl (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            in_fire,
    input  logic            out_fire,
    input  rau_pkg::sts_t   sts,
    output rau_pkg::cmd_t   cmd,
    output logic            busy,
    output logic            res_valid
);
    import rau_pkg::*;

    state_t state_reg, state_next;

    // state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // next state and commands
    always_comb begin
        state_next = state_reg;
        cmd = '0;
        busy = 1'b1;
        res_valid = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                busy = 1'b0;
                if (in_fire) begin
                    cmd.load = 1'b1;
                    state_next = ST_MUL1;
                end
            end
            ST_MUL1: begin
                cmd.mul1 = 1'b1;
                state_next = ST_MUL2;
            end
            ST_MUL2: begin
                cmd.mul2 = 1'b1;
                state_next = ST_COMB;
            end
            ST_COMB: begin
                cmd.comb = 1'b1;
                state_next = ST_GCD;
            end
            ST_GCD: begin
                if (sts.zero_part) begin
                    state_next = ST_OUT;
                end else if (sts.gcd_done) begin
                    cmd.div_start_n = 1'b1;
                    state_next = ST_DIVN;
                end else begin
                    cmd.gcd_step = 1'b1;
                end
            end
            ST_DIVN: begin
                if (sts.div_done) begin
                    cmd.fin_n = 1'b1;
                    cmd.div_start_d = 1'b1;
                    state_next = ST_DIVD;
                end else begin
                    cmd.div_step = 1'b1;
                end
            end
            ST_DIVD: begin
                if (sts.div_done) begin
                    cmd.fin_d = 1'b1;
                    state_next = ST_OUT;
                end else begin
                    cmd.div_step = 1'b1;
                end
            end
            ST_OUT: begin
                res_valid = 1'b1;
                if (out_fire) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // a result is only offered from the output state
    assert property (@(posedge aclk) disable iff (!aresetn)
        res_valid |-> state_reg == ST_OUT)
        else $error("result offered outside output state");
    // an accepted item always starts the multiply sequence
    assert property (@(posedge aclk) disable iff (!aresetn)
        in_fire |=> state_reg == ST_MUL1)
        else $error("accept did not start work");
    // no accept while busy
    assert property (@(posedge aclk) disable iff (!aresetn)
        busy |-> !cmd.load)
        else $error("load while busy");

endmodule

[rtl/rau_dp.sv]
// rational arithmetic unit: products, binary gcd and restoring divider
// depends on rau_pkg
module rau_dp #(
    parameter int OPERAND_BITS = 16
) (
    input  logic                        aclk,
    input  rau_pkg::cmd_t               cmd,
    input  logic [2:0]                  func,
    input  logic signed [OPERAND_BITS-1:0] num_a,
    input  logic signed [OPERAND_BITS-1:0] den_a,
    input  logic signed [OPERAND_BITS-1:0] num_b,
    input  logic signed [OPERAND_BITS-1:0] den_b,
    output rau_pkg::sts_t               sts,
    output logic signed [rau_pkg::NUM_W-1:0] num_out,
    output logic signed [rau_pkg::DEN_W-1:0] den_out
);
    import rau_pkg::*;

    localparam int PW = 2 * OPERAND_BITS;
    localparam int W = (PW + 2 > WORK_W) ? PW + 2 : WORK_W;
    localparam int CW = $clog2(W + 1);

    logic [2:0] func_reg;
    logic signed [OPERAND_BITS-1:0] na_reg, da_reg, nb_reg, db_reg;
    logic signed [PW-1:0] p1_reg, p2_reg, p3_reg;
    logic signed [W-1:0] n_reg, d_reg;
    logic [W-1:0] x_reg, y_reg, g_reg;
    logic [CW-1:0] sh_reg;
    logic [W-1:0] q_reg, r_reg, dvd_reg;
    logic [CW-1:0] cnt_reg;
    logic neg_n_reg, neg_d_reg;
    logic signed [NUM_W-1:0] nout_reg;
    logic signed [DEN_W-1:0] dout_reg;
    logic signed [OPERAND_BITS-1:0] ma, mb;
    logic signed [W-1:0] sum_w;
    logic [W-1:0] r_sh, diff;
    logic is_ar;

    assign is_ar = (func_reg == FUNC_ADD) || (func_reg == FUNC_SUB);

    // operand select for the shared multiplier
    always_comb begin
        ma = na_reg;
        mb = db_reg;
        if (cmd.mul2) begin
            if (func_reg == FUNC_MUL) begin
                ma = na_reg;
                mb = nb_reg;
            end else begin
                ma = da_reg;
                mb = nb_reg;
            end
        end
    end

    // combine cross products
    always_comb begin
        case (func_reg)
            FUNC_ADD: sum_w = W'(p1_reg) + W'(p2_reg);
            FUNC_SUB: sum_w = W'(p1_reg) - W'(p2_reg);
            FUNC_MUL: sum_w = W'(p2_reg);
            FUNC_DIV: sum_w = W'(p1_reg);
            default:  sum_w = W'(na_reg);
        endcase
    end

    // one restoring division step
    assign r_sh = {r_reg[W-2:0], dvd_reg[W-1]};
    assign diff = r_sh - g_reg;

    // datapath registers
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            func_reg <= func;
            na_reg <= num_a;
            da_reg <= den_a;
            nb_reg <= num_b;
            db_reg <= den_b;
        end
        if (cmd.mul1) begin
            p1_reg <= ma * mb;
            p3_reg <= da_reg * db_reg;
        end
        if (cmd.mul2) begin
            p2_reg <= ma * mb;
        end
        if (cmd.comb) begin
            n_reg <= sum_w;
            if (is_ar || func_reg == FUNC_MUL) begin
                d_reg <= W'(p3_reg);
            end else if (func_reg == FUNC_DIV) begin
                d_reg <= W'(p2_reg);
            end else begin
                d_reg <= W'(da_reg);
            end
            x_reg <= sum_w[W-1] ? -sum_w : sum_w;
            neg_n_reg <= sum_w[W-1];
            sh_reg <= '0;
            nout_reg <= NUM_W'(sum_w);
        end
        if (cmd.comb) begin
            if (is_ar || func_reg == FUNC_MUL) begin
                y_reg <= p3_reg[PW-1] ? -W'(p3_reg) : W'(p3_reg);
                neg_d_reg <= p3_reg[PW-1];
                dout_reg <= DEN_W'(p3_reg);
            end else if (func_reg == FUNC_DIV) begin
                y_reg <= p2_reg[PW-1] ? -W'(p2_reg) : W'(p2_reg);
                neg_d_reg <= p2_reg[PW-1];
                dout_reg <= DEN_W'(p2_reg);
            end else begin
                y_reg <= da_reg[OPERAND_BITS-1] ? -W'(da_reg) : W'(da_reg);
                neg_d_reg <= da_reg[OPERAND_BITS-1];
                dout_reg <= DEN_W'(da_reg);
            end
        end
        // binary gcd step: strip common twos, then odd parts
        if (cmd.gcd_step) begin
            if (!x_reg[0] && !y_reg[0]) begin
                x_reg <= x_reg >> 1;
                y_reg <= y_reg >> 1;
                sh_reg <= sh_reg + 1'b1;
            end else if (!x_reg[0]) begin
                x_reg <= x_reg >> 1;
            end else if (!y_reg[0]) begin
                y_reg <= y_reg >> 1;
            end else if (x_reg >= y_reg) begin
                x_reg <= (x_reg - y_reg) >> 1;
            end else begin
                y_reg <= (y_reg - x_reg) >> 1;
            end
        end
        if (cmd.div_start_n) begin
            g_reg <= (x_reg == '0 ? y_reg : x_reg) << sh_reg;
        end
        if (cmd.div_start_n) begin
            dvd_reg <= n_reg[W-1] ? -n_reg : n_reg;
        end else if (cmd.div_start_d) begin
            dvd_reg <= d_reg[W-1] ? -d_reg : d_reg;
        end else if (cmd.div_step) begin
            dvd_reg <= dvd_reg << 1;
        end
        if (cmd.div_start_n || cmd.div_start_d) begin
            r_reg <= '0;
            q_reg <= '0;
            cnt_reg <= '0;
        end else if (cmd.div_step) begin
            r_reg <= diff[W-1] ? r_sh : diff;
            q_reg <= {q_reg[W-2:0], ~diff[W-1]};
            cnt_reg <= cnt_reg + 1'b1;
        end
        if (cmd.fin_n) begin
            nout_reg <= NUM_W'(neg_n_reg ? -q_reg : q_reg);
        end
        if (cmd.fin_d) begin
            dout_reg <= DEN_W'(neg_d_reg ? -q_reg : q_reg);
        end
    end

    assign sts.zero_part = (n_reg == '0) || (d_reg == '0);
    assign sts.gcd_done = (x_reg == '0) || (y_reg == '0);
    assign sts.div_done = (cnt_reg == CW'(W));
    assign num_out = nout_reg;
    assign den_out = dout_reg;

endmodule

[rtl/rational_arithmetic_unit_core.sv]
// rational arithmetic unit top level: handshakes, controller and datapath
// depends on rau_pkg, rau_ctrl, rau_dp
//
// channel   dir  tdata fields (lsb first)                 tuser
// s_axis    in   num_a, den_a, num_b, den_b               func
// m_axis    out  num_out, den_out, zero pad to 72 bits    none
//
// one item at a time: after the accept, the products and combine run through
// the MUL1, MUL2 and COMB states, then binary gcd steps, then two restoring
// divisions over the W-bit work width (W = 34 at 16-bit operands); zero parts
// skip reduction and go from the gcd state straight to the output state; the
// next accept waits for the return to the idle state after the result transfer.
// reset is synchronous active low and holds s_tready low; a stalled result
// holds m_tvalid and data.
module rational_arithmetic_unit_core #(
    parameter int OPERAND_BITS = 16
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [4*OPERAND_BITS-1:0]   s_tdata,   // num_a, den_a, num_b, den_b
    input  logic [2:0]                  s_tuser,   // func
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [71:0]                 m_tdata    // num_out, den_out, pad
);
    import rau_pkg::*;

    cmd_t cmd;
    sts_t sts;
    logic busy;
    logic in_fire, out_fire;
    logic signed [NUM_W-1:0] num_out;
    logic signed [DEN_W-1:0] den_out;

    assign s_tready = !busy && aresetn;
    assign in_fire = s_tvalid && s_tready;
    assign out_fire = m_tvalid && m_tready;

    // sequencing
    rau_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_fire   (in_fire),
        .out_fire  (out_fire),
        .sts       (sts),
        .cmd       (cmd),
        .busy      (busy),
        .res_valid (m_tvalid)
    );

    // arithmetic
    rau_dp #(.OPERAND_BITS(OPERAND_BITS)) u_dp (
        .aclk    (aclk),
        .cmd     (cmd),
        .func    (s_tuser),
        .num_a   (s_tdata[OPERAND_BITS-1:0]),
        .den_a   (s_tdata[2*OPERAND_BITS-1:OPERAND_BITS]),
        .num_b   (s_tdata[3*OPERAND_BITS-1:2*OPERAND_BITS]),
        .den_b   (s_tdata[4*OPERAND_BITS-1:3*OPERAND_BITS]),
        .sts     (sts),
        .num_out (num_out),
        .den_out (den_out)
    );

    assign m_tdata = {7'd0, den_out, num_out};

endmodule

[bench/tb_top.sv]
// self-checking bench for rational_arithmetic_unit_core: fraction ops with gcd reduction
// depends on rau_pkg and the rational_arithmetic_unit_core rtl
`timescale 1ns / 1ps

class fraction_scoreboard;
    logic [32:0] want_num [$];
    logic [31:0] want_den [$];
    int          errors;
    int          checked;

    function new();
        errors  = 0;
        checked = 0;
    endfunction

    // largest common factor of two nonzero magnitudes
    function automatic longint unsigned common_factor(longint unsigned x, longint unsigned y);
        longint unsigned r;
        while (y != 0) begin
            r = x % y;
            x = y;
            y = r;
        end
        return x;
    endfunction

    // work out the reduced fraction for one accepted operand transfer
    function void note_operands(logic [2:0] op, logic signed [15:0] na, logic signed [15:0] da,
                                logic signed [15:0] nb, logic signed [15:0] db);
        longint n, d;
        longint unsigned an, ad, g;
        case (op)
            rau_pkg::FUNC_ADD: begin
                n = longint'(na) * db + longint'(da) * nb;
                d = longint'(da) * db;
            end
            rau_pkg::FUNC_SUB: begin
                n = longint'(na) * db - longint'(da) * nb;
                d = longint'(da) * db;
            end
            rau_pkg::FUNC_MUL: begin
                n = longint'(na) * nb;
                d = longint'(da) * db;
            end
            rau_pkg::FUNC_DIV: begin
                n = longint'(na) * db;
                d = longint'(da) * nb;
            end
            default: begin
                n = na;
                d = da;
            end
        endcase
        // zero parts pass through unreduced, signs kept as computed
        if (n != 0 && d != 0) begin
            an = (n < 0) ? -n : n;
            ad = (d < 0) ? -d : d;
            g  = common_factor(an, ad);
            n  = (n < 0) ? -longint'(an / g) : longint'(an / g);
            d  = (d < 0) ? -longint'(ad / g) : longint'(ad / g);
        end
        want_num.push_back(n[32:0]);
        want_den.push_back(d[31:0]);
    endfunction

    // compare one result transfer with the oldest expectation
    function void check_result(logic [71:0] data);
        logic [32:0] en;
        logic [31:0] ed;
        checked++;
        if (want_num.size() == 0) begin
            errors++;
            $display("%0t: unexpected result transfer %h", $time, data);
            return;
        end
        en = want_num.pop_front();
        ed = want_den.pop_front();
        if (data[32:0] !== en) begin
            errors++;
            $display("%0t: num_out expected %h actual %h", $time, en, data[32:0]);
        end
        if (data[64:33] !== ed) begin
            errors++;
            $display("%0t: den_out expected %h actual %h", $time, ed, data[64:33]);
        end
        if (data[71:65] !== 7'd0) begin
            errors++;
            $display("%0t: pad expected 0 actual %h", $time, data[71:65]);
        end
    endfunction
endclass

module tb_top;
    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [63:0] s_tdata;    // num_a, den_a, num_b, den_b
    logic [2:0]  s_tuser;    // func
    logic        m_tvalid;
    logic        m_tready;
    logic [71:0] m_tdata;    // num_out, den_out, pad

    fraction_scoreboard board;
    int  cycles;
    bit  calm;          // no idling in the last part
    bit  hold_off;      // long receiver stall requested
    int  sent;

    rational_arithmetic_unit_core #(.OPERAND_BITS(16)) dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    initial begin
        aclk = 0;
        forever #2 aclk = ~aclk;
    end

    // cycle limit
    initial begin
        cycles = 0;
        forever begin
            @(posedge aclk);
            cycles++;
            if (cycles > 400000) begin
                $display("timeout after %0d cycles", cycles);
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    // result monitor
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            board.check_result(m_tdata);
    end

    // receiver: random stall bursts, one long hold-off on request
    initial begin
        int k;
        m_tready = 0;
        @(posedge aclk iff aresetn);
        forever begin
            if (hold_off) begin
                m_tready <= 0;
                for (k = 0; k < 600; k++) @(posedge aclk);
                hold_off = 0;
            end else if (!calm && $urandom_range(0, 3) == 0) begin
                m_tready <= 0;
                repeat ($urandom_range(1, 17)) @(posedge aclk);
            end else begin
                m_tready <= 1;
                repeat ($urandom_range(1, 20)) @(posedge aclk);
            end
        end
    end

    // offer one operand transfer and wait for acceptance
    task automatic send_operands(logic [2:0] op, logic [15:0] na, logic [15:0] da,
                                 logic [15:0] nb, logic [15:0] db);
        s_tvalid <= 1;
        s_tuser  <= op;
        s_tdata  <= {db, nb, da, na};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        board.note_operands(op, na, da, nb, db);
        sent++;
        if (!calm && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 0;
            repeat ($urandom_range(1, 17)) @(posedge aclk);
        end
    endtask

    function automatic logic [15:0] pick_value();
        case ($urandom_range(0, 7))
            0: return 16'h8000;
            1: return 16'h7fff;
            2: return 16'h0000;
            3: return 16'($signed($urandom_range(0, 24)) - 12);
            4: return 16'($urandom_range(1, 64) * 6);
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic send_random();
        logic [2:0] op;
        op = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(5, 7)) : 3'($urandom_range(0, 4));
        send_operands(op, pick_value(), pick_value(), pick_value(), pick_value());
    endtask

    task automatic wait_drained();
        while (board.want_num.size() != 0) @(posedge aclk);
    endtask

    initial begin
        int i;
        board    = new();
        calm     = 0;
        hold_off = 0;
        sent     = 0;
        aresetn  = 0;
        s_tvalid = 0;
        s_tdata  = '0;
        s_tuser  = '0;
        repeat (4) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        // directed: each operation, extremes, zero parts, unused codes
        send_operands(rau_pkg::FUNC_ADD, 16'd1, 16'd2, 16'd1, 16'd3);
        send_operands(rau_pkg::FUNC_SUB, 16'd1, 16'd2, 16'd1, 16'd2);
        send_operands(rau_pkg::FUNC_MUL, 16'd6, 16'd4, 16'd2, 16'd9);
        send_operands(rau_pkg::FUNC_DIV, 16'd3, 16'd4, 16'd9, 16'd8);
        send_operands(rau_pkg::FUNC_RED, 16'd6, 16'd8, 16'd0, 16'd0);
        send_operands(rau_pkg::FUNC_RED, 16'd6, 16'd0, 16'hffff, 16'hffff);
        send_operands(rau_pkg::FUNC_RED, 16'd0, 16'd8, 16'd5, 16'd5);
        send_operands(rau_pkg::FUNC_RED, 16'hfffa, 16'd8, 16'd0, 16'd0);
        send_operands(rau_pkg::FUNC_RED, 16'd6, 16'hfff8, 16'd0, 16'd0);
        send_operands(rau_pkg::FUNC_ADD, 16'h8000, 16'h8000, 16'h8000, 16'h8000);
        send_operands(rau_pkg::FUNC_SUB, 16'h8000, 16'h7fff, 16'h7fff, 16'h8000);
        send_operands(rau_pkg::FUNC_MUL, 16'h8000, 16'h7fff, 16'h8000, 16'h7fff);
        send_operands(rau_pkg::FUNC_DIV, 16'h8000, 16'h8000, 16'h7fff, 16'h7fff);
        send_operands(rau_pkg::FUNC_DIV, 16'd5, 16'd3, 16'd0, 16'd7);
        send_operands(rau_pkg::FUNC_ADD, 16'd1, 16'd0, 16'd1, 16'd0);
        send_operands(rau_pkg::FUNC_SUB, 16'hffff, 16'hffff, 16'hffff, 16'hffff);
        send_operands(3'd5, 16'd10, 16'd4, 16'd1, 16'd1);
        send_operands(3'd6, 16'h7fff, 16'h7fff, 16'd1, 16'd1);
        send_operands(3'd7, 16'h8000, 16'd2, 16'd1, 16'd1);
        send_operands(rau_pkg::FUNC_RED, 16'h5555, 16'haaaa, 16'h5555, 16'haaaa);

        // sender pause until all results are back
        s_tvalid <= 0;
        wait_drained();

        // long receiver hold-off while the sender keeps offering
        hold_off = 1;
        for (i = 0; i < 8; i++) send_random();

        for (i = 0; i < 320; i++) send_random();
        calm = 1;
        for (i = 0; i < 60; i++) send_random();
        s_tvalid <= 0;

        wait_drained();
        repeat (200) @(posedge aclk);
        $display("covered %0d operand transfers, %0d results checked", sent, board.checked);
        $display("all five operations, unused codes, extremes, zero parts and stalls exercised");
        if (board.errors == 0 && board.want_num.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end
endmodule

[rational_arithmetic_unit_core.f]
rtl/rau_pkg.sv
rtl/rau_ctrl.sv
rtl/rau_dp.sv
rtl/rational_arithmetic_unit_core.sv
bench/tb_top.sv
